/* design/lrutc_pkg.sv */
// Package with the transfer types, command codes and default slot count of the LRU token slot table.
`timescale 1ns / 1ps

package lrutc_pkg;

	// Default number of slots in the table.
	localparam int unsigned SLOT_COUNT_DEF = 8;

	// Command codes carried in the request.
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_FLUSH   = 1'b1;

	// Fields of one request transfer.
	typedef struct packed {
		logic        command;
		logic [31:0] token;
		logic [31:0] stamp_limit;
	} req_t;

	// Fields of one response transfer.
	typedef struct packed {
		logic        hit;
		logic [2:0]  slot_id;
		logic        evict_valid;
		logic [31:0] evicted_token;
		logic [31:0] slot_stamp;
		logic [3:0]  released_count;
	} rsp_t;

endpackage

/* design/lru_token_cache_slot_policy.sv */
// Fully associative token slot table with stamp-based LRU replacement and flush.
// The request is captured in idle; the scan then reads every slot in turn into the check stage,
// a drain step empties the check stage and a write step updates the chosen slot and registers
// the response, waiting while a held response is stalled. New requests are taken only in idle.
// Reset (arst_n low, asynchronous) empties every slot and zeroes the use counter at once;
// no clearing pass is needed since slot contents are qualified by per-slot live bits.
`timescale 1ns / 1ps

module lru_token_cache_slot_policy #(
	parameter int unsigned SLOT_COUNT = lrutc_pkg::SLOT_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  lrutc_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output lrutc_pkg::rsp_t rsp
);

	localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	state_t state_q;

	// Slot storage: keys and stamps in memories, live bits in flip-flops.
	logic [31:0]           key_mem_q   [SLOT_COUNT];
	logic [31:0]           stamp_mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] live_q;
	logic [31:0]           use_counter_q;

	// Request held for the duration of the scan.
	logic        cmd_q;
	logic [31:0] token_q;
	logic [31:0] bound_q;

	// Scan read port and the check stage that follows it.
	logic [IW-1:0] ridx_q;
	logic          chk_valid_s1;
	logic [IW-1:0] chk_idx_s1;
	logic [31:0]   key_rd_s1;
	logic [31:0]   stamp_rd_s1;

	// Running scan results.
	logic          found_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] vic_idx_q;
	logic          vic_live_q;
	logic [31:0]   vic_key_q;
	logic [3:0]    count_q;

	// Output register.
	logic            rsp_valid_q;
	lrutc_pkg::rsp_t rsp_q;

	// Shared compare unit on the slot being checked.
	logic          chk_live;
	logic [31:0]   chk_stamp;
	logic          chk_take;
	logic          chk_match;
	logic          chk_first;
	logic          wr_fire;
	logic [IW-1:0] sel_idx;
	logic [IW+2:0] sel_wide;
	logic [31:0]   next_stamp;

	assign chk_live   = live_q[chk_idx_s1];
	assign chk_stamp  = chk_live ? stamp_rd_s1 : 32'd0;
	assign chk_take   = chk_stamp <= bound_q;
	assign chk_match  = chk_live && (key_rd_s1 == token_q);
	assign chk_first  = chk_idx_s1 == '0;

	assign wr_fire    = (state_q == S_WRITE) && (!rsp_valid_q || !rsp_stall);
	assign sel_idx    = found_q ? hit_idx_q : vic_idx_q;
	assign sel_wide   = (IW + 3)'(sel_idx);
	assign next_stamp = use_counter_q + 32'd1;

	assign req_stall  = state_q != S_IDLE;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// Sequencer, live bits, counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			live_q        <= '0;
			use_counter_q <= '0;
			chk_valid_s1  <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					chk_valid_s1 <= 1'b1;
					if (ridx_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					chk_valid_s1 <= 1'b0;
					state_q      <= S_WRITE;
				end
				S_WRITE: begin
					if (wr_fire) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (cmd_q == lrutc_pkg::CMD_FLUSH) begin
							live_q <= '0;
						end else begin
							use_counter_q   <= next_stamp;
							live_q[sel_idx] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Memories, scan datapath and response payload.
	always_ff @(posedge clk) begin
		key_rd_s1   <= key_mem_q[ridx_q];
		stamp_rd_s1 <= stamp_mem_q[ridx_q];
		chk_idx_s1  <= ridx_q;

		// Capture the request and reset the running results.
		if (state_q == S_IDLE) begin
			cmd_q      <= req.command;
			token_q    <= req.token;
			bound_q    <= req.stamp_limit;
			ridx_q     <= '0;
			found_q    <= 1'b0;
			hit_idx_q  <= '0;
			vic_idx_q  <= '0;
			vic_live_q <= 1'b0;
			vic_key_q  <= '0;
			count_q    <= '0;
		end

		if (state_q == S_SCAN && ridx_q != LAST_IDX) begin
			ridx_q <= ridx_q + 1'b1;
		end

		// One slot checked per cycle: first hit, latest minimal stamp, live count.
		if (chk_valid_s1) begin
			if (chk_match && !found_q) begin
				found_q   <= 1'b1;
				hit_idx_q <= chk_idx_s1;
			end
			if (chk_take) begin
				bound_q <= chk_stamp;
			end
			if (chk_take || chk_first) begin
				vic_idx_q  <= chk_idx_s1;
				vic_live_q <= chk_live;
				vic_key_q  <= key_rd_s1;
			end
			if (chk_live && count_q != 4'hF) begin
				count_q <= count_q + 4'd1;
			end
		end

		// Final update of the chosen slot and the response.
		if (wr_fire) begin
			if (cmd_q == lrutc_pkg::CMD_FLUSH) begin
				rsp_q.hit            <= 1'b0;
				rsp_q.slot_id        <= 3'd0;
				rsp_q.evict_valid    <= 1'b0;
				rsp_q.evicted_token  <= 32'd0;
				rsp_q.slot_stamp     <= 32'd0;
				rsp_q.released_count <= count_q;
			end else begin
				stamp_mem_q[sel_idx] <= next_stamp;
				if (!found_q) begin
					key_mem_q[sel_idx] <= token_q;
				end
				rsp_q.hit            <= found_q;
				rsp_q.slot_id        <= sel_wide[2:0];
				rsp_q.evict_valid    <= !found_q && vic_live_q;
				rsp_q.evicted_token  <= (!found_q && vic_live_q) ? vic_key_q : 32'd0;
				rsp_q.slot_stamp     <= next_stamp;
				rsp_q.released_count <= 4'd0;
			end
		end
	end

	// A response only appears out of the write step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_WRITE))
		else $error("response raised outside the write step");

	// A hit never reports an eviction.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.hit |-> !rsp_q.evict_valid)
		else $error("hit response reports an eviction");

	// The scan index stays within the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> ridx_q <= LAST_IDX)
		else $error("scan index beyond last slot");

	// Each completed acquire advances the use counter by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_fire && cmd_q == lrutc_pkg::CMD_ACQUIRE
		|=> use_counter_q == $past(use_counter_q) + 32'd1)
		else $error("use counter did not advance on acquire");

	// A flush never releases more slots than the table holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> 32'(rsp_q.released_count) <= SLOT_COUNT)
		else $error("released count exceeds slot count");

endmodule

/* verif/tb_top.sv */
// Testbench for the LRU token slot table: random and directed requests against a shadow table.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned NSLOT = lrutc_pkg::SLOT_COUNT_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	lrutc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	lrutc_pkg::rsp_t rsp;

	lru_token_cache_slot_policy #(.SLOT_COUNT(NSLOT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Requests waiting to be driven, with the idle cycles that follow each one.
	lrutc_pkg::req_t req_backlog[$];
	int unsigned gap_backlog[$];

	// Responses predicted for accepted requests, oldest first.
	lrutc_pkg::rsp_t slot_rsp_due[$];

	// Shadow copy of the slot table.
	logic [31:0] slot_key[NSLOT];
	bit slot_live[NSLOT];
	logic [31:0] slot_age[NSLOT];
	logic [31:0] use_count = '0;

	int unsigned mismatches = 0;
	int unsigned hits = 0;
	int unsigned misses = 0;
	int unsigned evictions = 0;
	int unsigned flushes = 0;
	int unsigned checked = 0;

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			slot_key[i] = '0;
			slot_live[i] = 1'b0;
			slot_age[i] = '0;
		end
	end

	// Applies one request to the shadow table and returns the response it must produce.
	function automatic lrutc_pkg::rsp_t lookup_and_replace(lrutc_pkg::req_t r);
		lrutc_pkg::rsp_t o;
		logic [31:0] bound;
		int unsigned sel;
		int unsigned live_n;
		bit found;
		o = '0;
		sel = 0;
		live_n = 0;
		found = 1'b0;
		if (r.command == lrutc_pkg::CMD_FLUSH) begin
			for (int i = 0; i < NSLOT; i++) begin
				if (slot_live[i])
					live_n++;
				slot_key[i] = '0;
				slot_live[i] = 1'b0;
				slot_age[i] = '0;
			end
			o.released_count = (live_n > 15) ? 4'd15 : live_n[3:0];
			flushes++;
		end else begin
			for (int i = 0; i < NSLOT; i++) begin
				if (!found && slot_live[i] && slot_key[i] == r.token) begin
					sel = i;
					found = 1'b1;
				end
			end
			if (found) begin
				o.hit = 1'b1;
				hits++;
			end else begin
				// The last slot holding the smallest stamp at or below the limit wins.
				bound = r.stamp_limit;
				for (int i = 0; i < NSLOT; i++) begin
					if (slot_age[i] <= bound) begin
						bound = slot_age[i];
						sel = i;
					end
				end
				if (slot_live[sel]) begin
					o.evict_valid = 1'b1;
					o.evicted_token = slot_key[sel];
					evictions++;
				end
				slot_key[sel] = r.token;
				slot_live[sel] = 1'b1;
				misses++;
			end
			use_count = use_count + 32'd1;
			slot_age[sel] = use_count;
			o.slot_stamp = use_count;
			o.slot_id = sel[2:0];
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	// Request driver: holds the payload while stalled, then idles for the drawn gap.
	int unsigned hold_cycles = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			hold_cycles = 0;
		end else begin
			if (req_valid && !req_stall)
				slot_rsp_due.push_back(lookup_and_replace(req));
			if (!req_valid || !req_stall) begin
				if (hold_cycles > 0) begin
					hold_cycles--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					req <= req_backlog.pop_front();
					hold_cycles = gap_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: stalls at random, with calm stretches, and checks every transfer.
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	always @(posedge clk or negedge arst_n) begin
		lrutc_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else begin
			cycle_count++;
			if (rsp_valid && !rsp_stall) begin
				if (slot_rsp_due.size() == 0) begin
					report_mismatch("unexpected response", rsp.slot_stamp, '0);
				end else begin
					want = slot_rsp_due.pop_front();
					checked++;
					if (rsp.hit !== want.hit)
						report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
					if (rsp.slot_id !== want.slot_id)
						report_mismatch("slot_id", 32'(rsp.slot_id), 32'(want.slot_id));
					if (rsp.evict_valid !== want.evict_valid)
						report_mismatch("evict_valid", 32'(rsp.evict_valid),
							32'(want.evict_valid));
					if (rsp.evicted_token !== want.evicted_token)
						report_mismatch("evicted_token", rsp.evicted_token, want.evicted_token);
					if (rsp.slot_stamp !== want.slot_stamp)
						report_mismatch("slot_stamp", rsp.slot_stamp, want.slot_stamp);
					if (rsp.released_count !== want.released_count)
						report_mismatch("released_count", 32'(rsp.released_count),
							32'(want.released_count));
				end
				stall_left = ((cycle_count % 1024) < 200) ? 0 : $urandom_range(0, 3);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_stall <= (stall_left != 0);
		end
	end

	// Stimulus generation; the acquire count tracks the counter so limits land near live stamps.
	logic [31:0] acq_issued = '0;

	task automatic queue_req(logic cmd, logic [31:0] tok, logic [31:0] lim, bit calm);
		lrutc_pkg::req_t r;
		r.command = cmd;
		r.token = tok;
		r.stamp_limit = lim;
		req_backlog.push_back(r);
		gap_backlog.push_back(calm ? 0 : $urandom_range(0, 3));
		if (cmd == lrutc_pkg::CMD_ACQUIRE)
			acq_issued = acq_issued + 32'd1;
	endtask

	initial begin
		logic [31:0] token_pool[12];
		logic [31:0] tok;
		logic [31:0] lim;
		int unsigned pick;
		bit calm;

		for (int i = 0; i < 12; i++)
			token_pool[i] = $urandom;

		// Flush of an empty table, then fill every slot with extreme tokens.
		queue_req(lrutc_pkg::CMD_FLUSH, 32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
		// Hits on the extreme tokens.
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		// Plain eviction, eviction where no stamp qualifies, and a narrow limit.
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'hCAFE_F00D, 32'h0000_0000, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h0BAD_F00D, 32'h0000_0005, 1'b0);
		// Flush of a full table; a stale key must miss afterwards, then hit.
		queue_req(lrutc_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		queue_req(lrutc_pkg::CMD_ACQUIRE, 32'h1357_9BDF, 32'h0000_0000, 1'b0);
		queue_req(lrutc_pkg::CMD_FLUSH, 32'h0000_0000, 32'h0000_0000, 1'b0);

		// Random part: a small token pool gives hits, fresh tokens give misses.
		for (int n = 0; n < 1650; n++) begin
			calm = ((n / 150) % 3) == 2;
			pick = $urandom_range(0, 11);
			if ($urandom_range(0, 99) < 65) begin
				tok = token_pool[pick];
			end else begin
				tok = $urandom;
				token_pool[pick] = tok;
			end
			case ($urandom_range(0, 19))
				0, 1, 2: lim = acq_issued - $urandom_range(0, 10);
				3, 4: lim = 32'h0000_0000;
				5, 6, 7: lim = $urandom;
				default: lim = 32'hFFFF_FFFF;
			endcase
			if ($urandom_range(0, 31) == 0)
				queue_req(lrutc_pkg::CMD_FLUSH, $urandom, $urandom, calm);
			else
				queue_req(lrutc_pkg::CMD_ACQUIRE, tok, lim, calm);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent and every response seen, then a quiet wait before the final check.
		while (req_backlog.size() != 0 || req_valid || hold_cycles != 0
			|| slot_rsp_due.size() != 0)
			@(posedge clk);
		repeat (NSLOT + 12) @(posedge clk);
		if (slot_rsp_due.size() != 0)
			report_mismatch("responses still outstanding", slot_rsp_due.size(), 0);

		$display("Checked %0d responses: %0d hits, %0d misses, %0d evictions, %0d flushes.",
			checked, hits, misses, evictions, flushes);
		$display("Use counter reached %0d; mismatches: %0d.", use_count, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(2_000_000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
